FILE: hw/rtl/pressure_temperature_compensation_defines.svh
// Assertion macros shared by the checker of the pressure and temperature compensation block.
// Depends on nothing; included by the checker file by its bare name.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// The consequent must hold at the same edge as the antecedent.
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc checker: implication failed");

// The consequent must hold after the antecedent, delayed by the dly argument.
`define PTC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("ptc checker: delayed implication failed");

`endif

FILE: hw/rtl/ptc_pkg.sv
// Types and constants of the pressure and temperature compensation block.
// Depends on nothing; used by the datapath, the top level and the checker.
package ptc_pkg;

  // One input word: a pair of raw converter readings.
  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [31:0] pressure_deci_mbar;
  } out_word_t;

  // The six calibration words as held in configuration.
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } cal_t;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_t;

  // Band limits in hundredths of a degree.
  localparam int TEMP_REF_CENTI  = 2000;
  localparam int TEMP_VLOW_CENTI = -1500;

  // Number of register stages from an accepted word to the result strobe.
  localparam int PIPE_LATENCY = 11;

endpackage

FILE: hw/rtl/ptc_pipe.sv
// Eleven-stage compensation datapath: raw readings and calibration words in, results out.
// Depends on ptc_pkg for the word types, the calibration struct and the band limits.
module ptc_pipe
  import ptc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_word,
  input  cal_t      cal,
  output logic      out_valid,
  output out_word_t out_word
);

  // Valid bits, one per stage; bit 0 belongs to stage one.
  logic [PIPE_LATENCY-1:0] vld_r;
  logic [PIPE_LATENCY-1:0] vld_nxt;

  assign vld_nxt = {vld_r[PIPE_LATENCY-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage one: temperature difference against the reference.
  logic signed [24:0] dt_nxt;
  logic signed [24:0] dt_s1_r;
  logic        [23:0] d1_s1_r;

  assign dt_nxt = $signed({1'b0, in_word.raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

  always_ff @(posedge clk) begin
    dt_s1_r <= dt_nxt;
    d1_s1_r <= in_word.raw_pressure;
  end

  // Stage two: the four products of the difference, in parallel.
  logic signed [41:0] m6_nxt;
  logic signed [41:0] m4_nxt;
  logic signed [41:0] m3_nxt;
  logic signed [49:0] dtsq_nxt;
  logic signed [41:0] m6_s2_r;
  logic signed [41:0] m4_s2_r;
  logic signed [41:0] m3_s2_r;
  logic        [47:0] dtsq_s2_r;
  logic        [23:0] d1_s2_r;

  assign m6_nxt   = dt_s1_r * $signed({1'b0, cal.c6});
  assign m4_nxt   = dt_s1_r * $signed({1'b0, cal.c4});
  assign m3_nxt   = dt_s1_r * $signed({1'b0, cal.c3});
  assign dtsq_nxt = dt_s1_r * dt_s1_r;

  always_ff @(posedge clk) begin
    m6_s2_r   <= m6_nxt;
    m4_s2_r   <= m4_nxt;
    m3_s2_r   <= m3_nxt;
    dtsq_s2_r <= dtsq_nxt[47:0];
    d1_s2_r   <= d1_s1_r;
  end

  // Stage three: first-order temperature, band decision, first-order offset
  // and sensitivity, and the second-order temperature term.
  logic signed [18:0] dev_nxt;
  logic signed [19:0] temp_nxt;
  logic signed [19:0] low_nxt;
  logic               band_low_nxt;
  logic               band_vlow_nxt;
  logic        [17:0] t2_low;
  logic        [50:0] dtsq7;
  logic        [17:0] t2_nxt;
  logic signed [39:0] off_a_nxt;
  logic signed [39:0] sens_a_nxt;
  logic signed [18:0] dev_s3_r;
  logic signed [19:0] temp_s3_r;
  logic signed [18:0] low_s3_r;
  logic               band_low_s3_r;
  logic               band_vlow_s3_r;
  logic        [17:0] t2_s3_r;
  logic signed [39:0] off_a_s3_r;
  logic signed [39:0] sens_a_s3_r;
  logic        [23:0] d1_s3_r;

  // The upper bits of the product are its floor division by 2^23.
  assign dev_nxt       = $signed(m6_s2_r[41:23]);
  assign temp_nxt      = 20'(dev_nxt) + 20'(TEMP_REF_CENTI);
  assign low_nxt       = 20'(dev_nxt) + 20'(TEMP_REF_CENTI - TEMP_VLOW_CENTI);
  assign band_low_nxt  = dev_nxt[18];
  assign band_vlow_nxt = dev_nxt < 19'(TEMP_VLOW_CENTI - TEMP_REF_CENTI);

  // Below the reference three times the square over 2^33, above it seven times over 2^37.
  assign t2_low = {2'b00, dtsq_s2_r[47:33], 1'b0} + {3'b000, dtsq_s2_r[47:33]};
  assign dtsq7  = {dtsq_s2_r, 3'b000} - {3'b000, dtsq_s2_r};
  assign t2_nxt = band_low_nxt ? t2_low : {4'b0000, dtsq7[50:37]};

  assign off_a_nxt  = $signed({8'h00, cal.c2, 16'h0000}) + 40'($signed(m4_s2_r[41:7]));
  assign sens_a_nxt = $signed({9'h000, cal.c1, 15'h0000}) + 40'($signed(m3_s2_r[41:8]));

  always_ff @(posedge clk) begin
    dev_s3_r       <= dev_nxt;
    temp_s3_r      <= temp_nxt;
    low_s3_r       <= $signed(low_nxt[18:0]);
    band_low_s3_r  <= band_low_nxt;
    band_vlow_s3_r <= band_vlow_nxt;
    t2_s3_r        <= t2_nxt;
    off_a_s3_r     <= off_a_nxt;
    sens_a_s3_r    <= sens_a_nxt;
    d1_s3_r        <= d1_s2_r;
  end

  // Stage four: squares of the band deviations and the final temperature.
  logic signed [37:0] sq_nxt;
  logic signed [37:0] lsq_nxt;
  logic signed [20:0] temp_out_nxt;
  logic        [34:0] sq_s4_r;
  logic        [34:0] lsq_s4_r;
  logic signed [18:0] temp_out_s4_r;
  logic               band_low_s4_r;
  logic               band_vlow_s4_r;
  logic signed [39:0] off_a_s4_r;
  logic signed [39:0] sens_a_s4_r;
  logic        [23:0] d1_s4_r;

  assign sq_nxt       = dev_s3_r * dev_s3_r;
  assign lsq_nxt      = low_s3_r * low_s3_r;
  assign temp_out_nxt = 21'(temp_s3_r) - $signed({3'b000, t2_s3_r});

  always_ff @(posedge clk) begin
    sq_s4_r        <= sq_nxt[34:0];
    lsq_s4_r       <= lsq_nxt[34:0];
    temp_out_s4_r  <= $signed(temp_out_nxt[18:0]);
    band_low_s4_r  <= band_low_s3_r;
    band_vlow_s4_r <= band_vlow_s3_r;
    off_a_s4_r     <= off_a_s3_r;
    sens_a_s4_r    <= sens_a_s3_r;
    d1_s4_r        <= d1_s3_r;
  end

  // Stage five: second-order offset and sensitivity terms for the band.
  logic [36:0] sq3;
  logic [36:0] sq5;
  logic [37:0] lsq7;
  logic [37:0] off2_nxt;
  logic [37:0] sens2_nxt;
  logic [37:0] off2_s5_r;
  logic [37:0] sens2_s5_r;
  logic signed [18:0] temp_out_s5_r;
  logic signed [39:0] off_a_s5_r;
  logic signed [39:0] sens_a_s5_r;
  logic        [23:0] d1_s5_r;

  assign sq3  = {1'b0, sq_s4_r, 1'b0} + {2'b00, sq_s4_r};
  assign sq5  = {sq_s4_r, 2'b00} + {2'b00, sq_s4_r};
  assign lsq7 = {lsq_s4_r, 3'b000} - {3'b000, lsq_s4_r};

  always_comb begin
    if (band_low_s4_r) begin
      off2_nxt  = {2'b00, sq3[36:1]};
      sens2_nxt = {4'h0, sq5[36:3]};
      if (band_vlow_s4_r) begin
        off2_nxt  = off2_nxt + lsq7;
        sens2_nxt = sens2_nxt + {1'b0, lsq_s4_r, 2'b00};
      end
    end else begin
      off2_nxt  = {7'h00, sq_s4_r[34:4]};
      sens2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    off2_s5_r     <= off2_nxt;
    sens2_s5_r    <= sens2_nxt;
    temp_out_s5_r <= temp_out_s4_r;
    off_a_s5_r    <= off_a_s4_r;
    sens_a_s5_r   <= sens_a_s4_r;
    d1_s5_r       <= d1_s4_r;
  end

  // Stage six: compensated offset and sensitivity.
  logic signed [39:0] off_nxt;
  logic signed [39:0] sens_nxt;
  logic signed [39:0] off_s6_r;
  logic signed [39:0] sens_s6_r;
  logic signed [18:0] temp_out_s6_r;
  logic        [23:0] d1_s6_r;

  assign off_nxt  = off_a_s5_r - $signed({2'b00, off2_s5_r});
  assign sens_nxt = sens_a_s5_r - $signed({2'b00, sens2_s5_r});

  always_ff @(posedge clk) begin
    off_s6_r      <= off_nxt;
    sens_s6_r     <= sens_nxt;
    temp_out_s6_r <= temp_out_s5_r;
    d1_s6_r       <= d1_s5_r;
  end

  // Stage seven: sensitivity times raw pressure as two partial products.
  logic signed [44:0] pp_hi_nxt;
  logic        [43:0] pp_lo_nxt;
  logic signed [44:0] pp_hi_s7_r;
  logic        [43:0] pp_lo_s7_r;
  logic signed [39:0] off_s7_r;
  logic signed [18:0] temp_out_s7_r;

  assign pp_hi_nxt = $signed(sens_s6_r[39:20]) * $signed({1'b0, d1_s6_r});
  assign pp_lo_nxt = sens_s6_r[19:0] * d1_s6_r;

  always_ff @(posedge clk) begin
    pp_hi_s7_r    <= pp_hi_nxt;
    pp_lo_s7_r    <= pp_lo_nxt;
    off_s7_r      <= off_s6_r;
    temp_out_s7_r <= temp_out_s6_r;
  end

  // Stage eight: the partial products joined into the full product.
  logic signed [64:0] prod_nxt;
  logic signed [64:0] prod_s8_r;
  logic signed [39:0] off_s8_r;
  logic signed [18:0] temp_out_s8_r;

  assign prod_nxt = (65'(pp_hi_s7_r) <<< 20) + $signed({21'h000000, pp_lo_s7_r});

  always_ff @(posedge clk) begin
    prod_s8_r     <= prod_nxt;
    off_s8_r      <= off_s7_r;
    temp_out_s8_r <= temp_out_s7_r;
  end

  // Stage nine: product over 2^21, truncated toward zero by biasing negatives.
  logic signed [64:0] prod_biased;
  logic signed [43:0] q1_s9_r;
  logic signed [39:0] off_s9_r;
  logic signed [18:0] temp_out_s9_r;

  assign prod_biased = prod_s8_r + $signed({44'h0, {21{prod_s8_r[64]}}});

  always_ff @(posedge clk) begin
    q1_s9_r       <= $signed(prod_biased[64:21]);
    off_s9_r      <= off_s8_r;
    temp_out_s9_r <= temp_out_s8_r;
  end

  // Stage ten: offset removed.
  logic signed [45:0] diff_nxt;
  logic signed [45:0] diff_s10_r;
  logic signed [18:0] temp_out_s10_r;

  assign diff_nxt = 46'(q1_s9_r) - 46'(off_s9_r);

  always_ff @(posedge clk) begin
    diff_s10_r     <= diff_nxt;
    temp_out_s10_r <= temp_out_s9_r;
  end

  // Stage eleven: pressure over 2^15, truncated toward zero. The operand ranges keep
  // the quotient within 31 bits, so the signed 32-bit limits are never reached and the
  // saturation reduces to a sign extension.
  logic signed [45:0] diff_biased;
  out_word_t          out_word_r;

  assign diff_biased = diff_s10_r + $signed({31'h0, {15{diff_s10_r[45]}}});

  always_ff @(posedge clk) begin
    out_word_r.temperature_centi  <= temp_out_s10_r;
    out_word_r.pressure_deci_mbar <= 32'($signed(diff_biased[45:15]));
  end

  assign out_valid = vld_r[PIPE_LATENCY-1];
  assign out_word  = out_word_r;

endmodule

FILE: hw/rtl/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation block: calibration registers
// and the command handshake around the datapath. Depends on ptc_pkg and ptc_pipe.
//
//   channel  ports                                   moves
//   input    start, busy, in_word                     raw temperature and pressure word
//   result   out_valid, out_word                      compensated temperature and pressure
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data calibration word C1 to C6
//
// A word is taken in every cycle; busy is always low. Its result appears on out_word
// with out_valid once it has passed one register per datapath stage.
// Configuration writes complete in the cycle they are offered; indexes six and seven are
// dropped. Reset is synchronous and clears the calibration words and the stage valid bits.
// The receiver cannot stall, so the pipeline advances on every clock.
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  cal_t cal_r;
  cal_t cal_nxt;

  // Calibration register writes.
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_C1:  cal_nxt.c1 = cfg_data;
        CFG_C2:  cal_nxt.c2 = cfg_data;
        CFG_C3:  cal_nxt.c3 = cfg_data;
        CFG_C4:  cal_nxt.c4 = cfg_data;
        CFG_C5:  cal_nxt.c5 = cfg_data;
        CFG_C6:  cal_nxt.c6 = cfg_data;
        default: cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // The datapath takes a word every cycle and the configuration port never waits.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  ptc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_word   (in_word),
    .cal       (cal_r),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: hw/rtl/ptc_checker.sv
// Port-level checker of the pressure and temperature compensation block and its bind.
// Depends on ptc_pkg and on the assertion macros of the defines header.
`include "pressure_temperature_compensation_defines.svh"

module ptc_checker
  import ptc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  logic accept;

  assign accept = start && !busy;

  // Every accepted word gives exactly one strobe at the end of the pipeline.
  `PTC_ASSERT_DLY(ast_result_follows, clk, rst_n, accept, PIPE_LATENCY, out_valid)
  `PTC_ASSERT_IMP(ast_result_has_word, clk, rst_n, out_valid, $past(accept, PIPE_LATENCY))

  // A command and a configuration write are never held off.
  `PTC_ASSERT_IMP(ast_start_taken, clk, rst_n, start, !busy)
  `PTC_ASSERT_IMP(ast_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: bench/tb_top.sv
// Self-checking bench for the pressure and temperature compensation block.
// Depends on ptc_pkg and the RTL top level; a clocked driver and monitor work
// against an in-bench predictor of the compensation arithmetic.
module tb_top;
  import ptc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  // Divisors of the final pressure step and the signed 32-bit limits of its result.
  localparam longint SENS_SCALE = 64'sd2097152;
  localparam longint PRES_SCALE = 64'sd32768;
  localparam longint PRES_MAX   = 64'sd2147483647;
  localparam longint PRES_MIN   = -64'sd2147483648;

  // Indexes six and seven are not backed by a register.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic [CfgIdxW-1:0] CAL_ORDER [8] = '{
    CFG_C1, CFG_C2, CFG_C3, CFG_C4, CFG_C5, CFG_C6, CFG_SPARE_6, CFG_SPARE_7
  };

  // Calibration sets used across the run.
  localparam cal_t CAL_TYPICAL = '{c1: 16'd46372, c2: 16'd43981, c3: 16'd29059,
                                   c4: 16'd27842, c5: 16'd31553, c6: 16'd28165};
  localparam cal_t CAL_ONES  = '{default: 16'hFFFF};
  localparam cal_t CAL_ZERO  = '{default: 16'h0000};
  localparam cal_t CAL_MIXED = '{c1: 16'hFFFF, c2: 16'h0000, c3: 16'hFFFF,
                                 c4: 16'h0000, c5: 16'h0000, c6: 16'hFFFF};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  in_word_t            in_word   = '0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [15:0]         cfg_data  = '0;
  logic                busy;
  logic                out_valid;
  out_word_t           out_word;
  logic                cfg_ready;

  in_word_t  raw_pairs [$];
  out_word_t compensated_due [$];
  cal_t      cal_model = '0;
  out_word_t due_word;
  bit        idle_enabled = 1'b1;
  int        gap_left     = 0;
  int        fail_count   = 0;
  int        quiet_cycles = 0;

  pressure_temperature_compensation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // First- and second-order compensation of one raw pair at 64-bit width.
  function automatic out_word_t compensate(input in_word_t w, input cal_t cal);
    longint d2, d1, dt, temp, t2, off2, sens2, off, sens, pres, dtsq, dev, sq, low, lsq;
    out_word_t r;
    d2   = longint'(w.raw_temperature);
    d1   = longint'(w.raw_pressure);
    dt   = d2 - longint'(cal.c5) * 256;
    temp = ((dt * longint'(cal.c6)) >>> 23) + TEMP_REF_CENTI;
    dtsq = dt * dt;
    dev  = temp - TEMP_REF_CENTI;
    sq   = dev * dev;
    if (temp < TEMP_REF_CENTI) begin
      t2    = 3 * (dtsq >>> 33);
      off2  = (3 * sq) / 2;
      sens2 = (5 * sq) / 8;
      // The very cold band adds a further square term.
      if (temp < TEMP_VLOW_CENTI) begin
        low   = temp - TEMP_VLOW_CENTI;
        lsq   = low * low;
        off2  = off2 + 7 * lsq;
        sens2 = sens2 + 4 * lsq;
      end
    end else begin
      t2    = (dtsq * 7) >>> 37;
      off2  = sq / 16;
      sens2 = 0;
    end
    off  = longint'(cal.c2) * 65536 + ((longint'(cal.c4) * dt) >>> 7) - off2;
    sens = longint'(cal.c1) * 32768 + ((longint'(cal.c3) * dt) >>> 8) - sens2;
    temp = temp - t2;
    pres = ((sens * d1) / SENS_SCALE - off) / PRES_SCALE;
    if (pres > PRES_MAX) begin
      pres = PRES_MAX;
    end else if (pres < PRES_MIN) begin
      pres = PRES_MIN;
    end
    r.temperature_centi  = temp[18:0];
    r.pressure_deci_mbar = pres[31:0];
    return r;
  endfunction

  // Raw temperature: extremes, anything, or close to the reference point.
  function automatic logic [23:0] pick_raw_temperature();
    longint base, offs, v;
    int shift;
    base = longint'(cal_model.c5) * 256;
    unique case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      1, 2, 3, 4: return 24'($urandom_range(0, 24'hFFFFFF));
      default: begin
        shift = $urandom_range(0, 23);
        offs  = longint'($urandom_range(0, (1 << shift) - 1));
        if ($urandom_range(0, 1)) offs = -offs;
        v = base + offs;
        return v[23:0];
      end
    endcase
  endfunction

  function automatic logic [23:0] pick_raw_pressure();
    unique case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("mismatch: %s", what);
  endtask

  task automatic queue_pair(input logic [23:0] d2, input logic [23:0] d1);
    in_word_t w;
    w.raw_temperature = d2;
    w.raw_pressure    = d1;
    raw_pairs.push_back(w);
  endtask

  task automatic queue_random(input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) queue_pair(pick_raw_temperature(), pick_raw_pressure());
  endtask

  // Writes all six calibration words, optionally followed by the two spare indexes.
  task automatic apply_calibration(input cal_t cal, input bit with_spare);
    logic [15:0] words [6];
    int n;
    words = '{cal.c1, cal.c2, cal.c3, cal.c4, cal.c5, cal.c6};
    n = with_spare ? 8 : 6;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CAL_ORDER[i];
      cfg_data  <= (i < 6) ? words[i] : 16'($urandom_range(0, 16'hFFFF));
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cal_model = cal;
  endtask

  // Holds the sender back until every awaited result has come, then lets the pipe empty.
  task automatic wait_drained();
    @(negedge clk);
    while (raw_pairs.size() != 0 || compensated_due.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Driver: offers the oldest queued word, predicting its result when it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        compensated_due.push_back(compensate(in_word, cal_model));
        raw_pairs.pop_front();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (raw_pairs.size() != 0) begin
        if (idle_enabled && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 7);
          start    <= 1'b0;
        end else begin
          start   <= 1'b1;
          in_word <= raw_pairs[0];
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (compensated_due.size() == 0) begin
        note_failure($sformatf("result with none awaited: temp %0d pres %0d",
                               out_word.temperature_centi, out_word.pressure_deci_mbar));
      end else begin
        due_word = compensated_due.pop_front();
        if (out_word.temperature_centi !== due_word.temperature_centi)
          note_failure($sformatf("temperature_centi expected %0d got %0d",
                                 due_word.temperature_centi, out_word.temperature_centi));
        if (out_word.pressure_deci_mbar !== due_word.pressure_deci_mbar)
          note_failure($sformatf("pressure_deci_mbar expected %0d got %0d",
                                 due_word.pressure_deci_mbar, out_word.pressure_deci_mbar));
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("** pressure_temperature_compensation: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Sequencer: reset, then calibration phases each followed by a full drain.
  initial begin : sequencer
    longint base, vlow_dt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Calibration still at its reset value.
    queue_random(30);
    wait_drained();

    // Datasheet-like calibration with directed corner words; spare indexes must be ignored.
    apply_calibration(CAL_TYPICAL, 1'b1);
    base    = longint'(CAL_TYPICAL.c5) * 256;
    vlow_dt = (longint'(TEMP_REF_CENTI - TEMP_VLOW_CENTI) << 23) / longint'(CAL_TYPICAL.c6);
    @(negedge clk);
    queue_pair(24'h000000, 24'h000000);
    queue_pair(24'hFFFFFF, 24'hFFFFFF);
    queue_pair(24'h000000, 24'hFFFFFF);
    queue_pair(24'hFFFFFF, 24'h000000);
    // Temperature exactly at the reference and one step either side.
    queue_pair(24'(base), 24'd6465444);
    queue_pair(24'(base - 1), 24'd6465444);
    queue_pair(24'(base + 1), 24'd6465444);
    // The boundary of the very cold band.
    queue_pair(24'(base - vlow_dt), 24'd6465444);
    queue_pair(24'(base - vlow_dt - 1), 24'd6465444);
    queue_pair(24'(base - vlow_dt + 1), 24'hFFFFFF);
    queue_pair(24'(base + (1 << 20)), 24'hFFFFFF);
    queue_pair(24'(base - (1 << 22)), 24'h000001);
    queue_pair(24'd8569150, 24'd6465444);
    queue_pair(24'hAAAAAA, 24'h555555);
    queue_pair(24'h555555, 24'hAAAAAA);
    queue_pair(24'h800000, 24'h800000);
    queue_pair(24'h7FFFFF, 24'h7FFFFF);
    queue_pair(24'h000001, 24'hFFFFFE);
    queue_random(200);
    wait_drained();

    // Extremes of the calibration words.
    apply_calibration(CAL_ONES, 1'b0);
    queue_random(150);
    wait_drained();

    apply_calibration(cal_t'({$urandom, $urandom, $urandom}), 1'b1);
    queue_random(150);
    wait_drained();

    apply_calibration(CAL_ZERO, 1'b0);
    queue_random(100);
    wait_drained();

    apply_calibration(CAL_MIXED, 1'b0);
    queue_random(120);
    wait_drained();

    // Last stretch at full rate with no gaps.
    apply_calibration(cal_t'({$urandom, $urandom, $urandom}), 1'b0);
    idle_enabled = 1'b0;
    queue_random(200);
    wait_drained();

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (compensated_due.size() != 0)
      note_failure($sformatf("%0d results never arrived", compensated_due.size()));
    if (fail_count == 0) begin
      $display("** pressure_temperature_compensation: PASSED **");
    end else begin
      $display("** pressure_temperature_compensation: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_pipe.sv
hw/rtl/pressure_temperature_compensation.sv
hw/rtl/ptc_checker.sv
bench/tb_top.sv
